FILE: rtl/tsbcc_pkg.sv
// Shared types, widths and reset values for the three-stage battery charge controller.
package tsbcc_pkg;

	// Default sizes of the timers and of the voltage sample.
	localparam int TIMER_BITS_DEF  = 32;
	localparam int SAMPLE_BITS_DEF = 24;

	// Fixed field widths.
	localparam int VOLT_W     = 24;
	localparam int PERIOD_W   = 32;
	localparam int LIMIT_W    = 24;
	localparam int DUTY_W     = 25;
	localparam int STAGE_W    = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Register reset values.
	localparam logic [VOLT_W-1:0]   BULK_VOLTAGE_RST   = VOLT_W'(2413796);
	localparam logic [VOLT_W-1:0]   FLOAT_VOLTAGE_RST  = VOLT_W'(2103450);
	localparam logic [PERIOD_W-1:0] FLOAT_PERIOD_RST   = PERIOD_W'(432000000);
	localparam logic [PERIOD_W-1:0] MAX_ABSORPTION_RST = PERIOD_W'(432000000);
	localparam logic [LIMIT_W-1:0]  DUTY_LIMIT_RST     = LIMIT_W'(8220835);

	// Charge stages, in the encoding shown on the stage output.
	typedef enum logic [STAGE_W-1:0] {
		STG_START      = 3'd0,
		STG_DUMP       = 3'd1,
		STG_BULK_SETUP = 3'd2,
		STG_BULK       = 3'd3,
		STG_ABSORB     = 3'd4,
		STG_FLOAT      = 3'd5
	} stage_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHARGE_ENABLE  = 3'd0,
		CFG_BULK_VOLTAGE   = 3'd1,
		CFG_FLOAT_VOLTAGE  = 3'd2,
		CFG_FLOAT_PERIOD   = 3'd3,
		CFG_MAX_ABSORPTION = 3'd4,
		CFG_DUTY_LIMIT     = 3'd5
	} cfg_idx_t;

	// Configuration register file.
	typedef struct packed {
		logic                charge_enable;
		logic [VOLT_W-1:0]   bulk_voltage;
		logic [VOLT_W-1:0]   float_voltage;
		logic [PERIOD_W-1:0] float_period;
		logic [PERIOD_W-1:0] max_absorption;
		logic [LIMIT_W-1:0]  duty_limit;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		charge_enable:  1'b0,
		bulk_voltage:   BULK_VOLTAGE_RST,
		float_voltage:  FLOAT_VOLTAGE_RST,
		float_period:   FLOAT_PERIOD_RST,
		max_absorption: MAX_ABSORPTION_RST,
		duty_limit:     DUTY_LIMIT_RST
	};

	// Control state carried from one tick to the next (timers travel apart).
	typedef struct packed {
		stage_t                    stage;
		logic signed [DUTY_W-1:0]  duty;
		logic                      pwm_on;
	} ctl_t;

	// One result item.
	typedef struct packed {
		logic signed [DUTY_W-1:0] duty;
		logic                     pwm_on;
		logic                     led_toggle;
		stage_t                   stage;
		logic                     active;
	} res_t;

endpackage

FILE: rtl/tsbcc_step.sv
// Next-state and result logic for one control tick of the charge controller.
module tsbcc_step #(
	parameter int TIMER_BITS  = tsbcc_pkg::TIMER_BITS_DEF,
	parameter int SAMPLE_BITS = tsbcc_pkg::SAMPLE_BITS_DEF
) (
	input  tsbcc_pkg::cfg_t         cfg,
	input  logic [SAMPLE_BITS-1:0]  sample,
	input  tsbcc_pkg::ctl_t         cur,
	input  logic [TIMER_BITS-1:0]   bulk_ticks,
	input  logic [TIMER_BITS-1:0]   absorb_ticks,
	input  logic [TIMER_BITS-1:0]   float_ticks,
	output tsbcc_pkg::ctl_t         nxt,
	output logic [TIMER_BITS-1:0]   bulk_ticks_nxt,
	output logic [TIMER_BITS-1:0]   absorb_ticks_nxt,
	output logic [TIMER_BITS-1:0]   float_ticks_nxt,
	output tsbcc_pkg::res_t         res
);

	localparam int CMP_W = (SAMPLE_BITS > tsbcc_pkg::VOLT_W) ? SAMPLE_BITS : tsbcc_pkg::VOLT_W;
	localparam int PW    = (TIMER_BITS + 3 > tsbcc_pkg::PERIOD_W) ?
		TIMER_BITS + 3 : tsbcc_pkg::PERIOD_W;
	localparam int DX_W  = tsbcc_pkg::DUTY_W + 1;
	localparam int DW    = tsbcc_pkg::DUTY_W;

	logic                    below_bulk;
	logic                    below_float;
	logic signed [DX_W-1:0]  duty_x;
	logic signed [DX_W-1:0]  lim_x;
	logic signed [DX_W-1:0]  neg_lim_x;
	logic signed [DX_W-1:0]  up_x;
	logic signed [DX_W-1:0]  dn_x;
	logic signed [DW-1:0]    duty_up;
	logic signed [DW-1:0]    duty_dn;
	logic [PW-1:0]           bulk_x;
	logic [PW-1:0]           five_x;
	logic [PW-1:0]           maxabs_x;
	logic [PW-1:0]           tmask_x;
	logic [PW-1:0]           cap1_x;
	logic [PW-1:0]           cap2_x;
	logic [PW-1:0]           fper_x;
	logic [TIMER_BITS-1:0]   absorb_load;
	logic [TIMER_BITS-1:0]   float_load;
	tsbcc_pkg::stage_t       work_stage;
	logic                    led;

	// Voltage compares against the two thresholds.
	assign below_bulk  = CMP_W'(sample) < CMP_W'(cfg.bulk_voltage);
	assign below_float = CMP_W'(sample) < CMP_W'(cfg.float_voltage);

	// Duty steps of one LSB, saturated at plus or minus the limit.
	assign duty_x    = $signed({cur.duty[DW-1], cur.duty});
	assign lim_x     = $signed({{(DX_W - tsbcc_pkg::LIMIT_W){1'b0}}, cfg.duty_limit});
	assign neg_lim_x = -lim_x;
	assign up_x      = duty_x + $signed(DX_W'(1));
	assign dn_x      = duty_x - $signed(DX_W'(1));
	assign duty_up   = (up_x > lim_x) ? lim_x[DW-1:0] : up_x[DW-1:0];
	assign duty_dn   = (dn_x < neg_lim_x) ? neg_lim_x[DW-1:0] : dn_x[DW-1:0];

	// Absorption time is five times the bulk time, capped by the register and the timer width.
	assign bulk_x      = PW'(bulk_ticks);
	assign five_x      = (bulk_x << 2) + bulk_x;
	assign maxabs_x    = PW'(cfg.max_absorption);
	assign tmask_x     = PW'({TIMER_BITS{1'b1}});
	assign cap1_x      = (five_x > maxabs_x) ? maxabs_x : five_x;
	assign cap2_x      = (cap1_x > tmask_x) ? tmask_x : cap1_x;
	assign absorb_load = cap2_x[TIMER_BITS-1:0];

	// The float period is fitted to the timer width.
	assign fper_x     = PW'(cfg.float_period);
	assign float_load = fper_x[TIMER_BITS-1:0];

	// Charge state machine: one tick per item, frozen while disabled.
	always_comb begin
		nxt              = cur;
		bulk_ticks_nxt   = bulk_ticks;
		absorb_ticks_nxt = absorb_ticks;
		float_ticks_nxt  = float_ticks;
		led              = 1'b0;
		work_stage       = cur.stage;
		if (cfg.charge_enable) begin
			// Start enables the PWM and runs dump in the same tick.
			if (cur.stage == tsbcc_pkg::STG_START) begin
				nxt.pwm_on = 1'b1;
				work_stage = tsbcc_pkg::STG_DUMP;
			end
			nxt.stage = work_stage;
			unique case (work_stage)
				tsbcc_pkg::STG_DUMP: begin
					if (below_bulk) begin
						nxt.stage = tsbcc_pkg::STG_BULK_SETUP;
						led       = 1'b1;
					end else begin
						nxt.duty = duty_up;
					end
				end
				tsbcc_pkg::STG_BULK_SETUP: begin
					bulk_ticks_nxt = '0;
					nxt.pwm_on     = 1'b0;
					nxt.stage      = tsbcc_pkg::STG_BULK;
				end
				tsbcc_pkg::STG_BULK: begin
					if (below_bulk) begin
						if (bulk_ticks != {TIMER_BITS{1'b1}}) begin
							bulk_ticks_nxt = bulk_ticks + TIMER_BITS'(1);
						end
					end else begin
						absorb_ticks_nxt = absorb_load;
						nxt.stage        = tsbcc_pkg::STG_ABSORB;
						led              = 1'b1;
					end
				end
				tsbcc_pkg::STG_ABSORB: begin
					nxt.pwm_on = 1'b1;
					nxt.duty   = below_bulk ? duty_dn : duty_up;
					if (absorb_ticks <= TIMER_BITS'(1)) begin
						absorb_ticks_nxt = '0;
						nxt.stage        = tsbcc_pkg::STG_FLOAT;
						float_ticks_nxt  = float_load;
					end else begin
						absorb_ticks_nxt = absorb_ticks - TIMER_BITS'(1);
					end
				end
				tsbcc_pkg::STG_FLOAT: begin
					nxt.duty = below_float ? duty_dn : duty_up;
					if (float_ticks <= TIMER_BITS'(1)) begin
						float_ticks_nxt = '0;
						nxt.stage       = tsbcc_pkg::STG_DUMP;
					end else begin
						float_ticks_nxt = float_ticks - TIMER_BITS'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Result item: duty is shown only on ticks that ran the controller.
	always_comb begin
		res.duty       = cfg.charge_enable ? nxt.duty : '0;
		res.pwm_on     = nxt.pwm_on;
		res.led_toggle = led;
		res.stage      = nxt.stage;
		res.active     = cfg.charge_enable;
	end

endmodule

FILE: rtl/three_stage_battery_charge_controller.sv
// Top level of the three-stage battery charge controller.
// Each bus-voltage item steps the charger (dump, bulk, absorption, float) by one
// control tick and yields exactly one result item. An item is registered on entry,
// the whole tick is worked out combinationally between that input register and the
// result register, and the charge state is updated in the same cycle, so one item
// is taken every clock while the result is not stalled, a rate set by the loop
// through the state registers. Its result is loaded into the result register when
// the item advances from the input register; a stalled result holds the input
// register and, through it, the input. Write the configuration registers only
// while no item is in flight; charge_enable at zero freezes all charge state and
// reports inactive results.
module three_stage_battery_charge_controller #(
	parameter int TIMER_BITS  = tsbcc_pkg::TIMER_BITS_DEF,
	parameter int SAMPLE_BITS = tsbcc_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Configuration write channel
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [tsbcc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tsbcc_pkg::CFG_DATA_W-1:0]       cfg_data,
	// Sample channel
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic [SAMPLE_BITS-1:0]                 bus_voltage,
	// Result channel
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic signed [tsbcc_pkg::DUTY_W-1:0]    duty,
	output logic                                   pwm_on,
	output logic                                   led_toggle,
	output logic [tsbcc_pkg::STAGE_W-1:0]          stage,
	output logic                                   active
);

	tsbcc_pkg::cfg_t        cfg_q;
	tsbcc_pkg::ctl_t        ctl_q;
	tsbcc_pkg::ctl_t        ctl_nxt;
	tsbcc_pkg::res_t        res_nxt;
	tsbcc_pkg::res_t        res_s2;
	logic [TIMER_BITS-1:0]  bulk_ticks_q;
	logic [TIMER_BITS-1:0]  absorb_ticks_q;
	logic [TIMER_BITS-1:0]  float_ticks_q;
	logic [TIMER_BITS-1:0]  bulk_ticks_nxt;
	logic [TIMER_BITS-1:0]  absorb_ticks_nxt;
	logic [TIMER_BITS-1:0]  float_ticks_nxt;
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] bus_voltage_s1;
	logic                   valid_s2;
	logic                   advance;
	logic                   in_take;
	logic                   out_take;

	// Handshake: an item moves on when the result register is free or being emptied.
	assign advance   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_take   = in_valid && !in_stall;
	assign out_take  = valid_s2 && !out_stall;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= tsbcc_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (tsbcc_pkg::cfg_idx_t'(cfg_index))
				tsbcc_pkg::CFG_CHARGE_ENABLE:  cfg_q.charge_enable  <= cfg_data[0];
				tsbcc_pkg::CFG_BULK_VOLTAGE:   cfg_q.bulk_voltage   <= cfg_data[tsbcc_pkg::VOLT_W-1:0];
				tsbcc_pkg::CFG_FLOAT_VOLTAGE:  cfg_q.float_voltage  <= cfg_data[tsbcc_pkg::VOLT_W-1:0];
				tsbcc_pkg::CFG_FLOAT_PERIOD:   cfg_q.float_period   <= cfg_data[tsbcc_pkg::PERIOD_W-1:0];
				tsbcc_pkg::CFG_MAX_ABSORPTION: cfg_q.max_absorption <= cfg_data[tsbcc_pkg::PERIOD_W-1:0];
				tsbcc_pkg::CFG_DUTY_LIMIT:     cfg_q.duty_limit     <= cfg_data[tsbcc_pkg::LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			bus_voltage_s1 <= bus_voltage;
		end
	end

	// One control tick.
	tsbcc_step #(
		.TIMER_BITS  (TIMER_BITS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_step (
		.cfg              (cfg_q),
		.sample           (bus_voltage_s1),
		.cur              (ctl_q),
		.bulk_ticks       (bulk_ticks_q),
		.absorb_ticks     (absorb_ticks_q),
		.float_ticks      (float_ticks_q),
		.nxt              (ctl_nxt),
		.bulk_ticks_nxt   (bulk_ticks_nxt),
		.absorb_ticks_nxt (absorb_ticks_nxt),
		.float_ticks_nxt  (float_ticks_nxt),
		.res              (res_nxt)
	);

	// Charge state registers, updated once per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.stage    <= tsbcc_pkg::STG_START;
			ctl_q.duty     <= '0;
			ctl_q.pwm_on   <= 1'b0;
			bulk_ticks_q   <= '0;
			absorb_ticks_q <= '0;
			float_ticks_q  <= '0;
		end else if (advance) begin
			ctl_q          <= ctl_nxt;
			bulk_ticks_q   <= bulk_ticks_nxt;
			absorb_ticks_q <= absorb_ticks_nxt;
			float_ticks_q  <= float_ticks_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_take) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid  = valid_s2;
	assign duty       = res_s2.duty;
	assign pwm_on     = res_s2.pwm_on;
	assign led_toggle = res_s2.led_toggle;
	assign stage      = res_s2.stage;
	assign active     = res_s2.active;

	// An item that moves on always lands in the result register.
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("item advanced but no result was registered");

	// The input side is held back only by a result that waits.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s2 && out_stall && valid_s1))
		else $error("input stalled without a waiting result");

	// A tick taken while disabled leaves the charge state untouched.
	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !cfg_q.charge_enable) |=>
		($stable(ctl_q) && $stable(bulk_ticks_q) && $stable(absorb_ticks_q)
		&& $stable(float_ticks_q)))
		else $error("charge state changed while disabled");

	// Leaving dump always lands in bulk setup with the LED pulse.
	a_dump_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && cfg_q.charge_enable && ctl_q.stage == tsbcc_pkg::STG_DUMP
		&& ctl_nxt.stage != tsbcc_pkg::STG_DUMP) |=>
		(res_s2.led_toggle && ctl_q.stage == tsbcc_pkg::STG_BULK_SETUP))
		else $error("dump stage exit went astray");

endmodule
